>>> rtl/tdca_pkg.sv
// ----------------------------------------------------------------------------
// tdca_pkg
// Shared types and constants of the time-of-day clock with alarm and
// backup words.
// ----------------------------------------------------------------------------
package tdca_pkg;

  localparam int unsigned BACKUP_WORDS = 10;
  localparam int unsigned BKP_ADDR_W   = (BACKUP_WORDS > 1) ? $clog2(BACKUP_WORDS) : 1;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned HOURS_W    = 5;
  localparam int unsigned MINUTES_W  = 6;
  localparam int unsigned SECONDS_W  = 6;
  localparam int unsigned BKP_IDX_W  = 4;
  localparam int unsigned BKP_DATA_W = 16;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned DAY_W      = 17;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLE = 1'd1;

  localparam logic [DAY_W-1:0] SECONDS_PER_DAY = 17'd86400;
  localparam logic [DAY_W-1:0] DAY_LAST        = 17'd86399;
  localparam logic [DAY_W-1:0] SECONDS_PER_HR  = 17'd3600;
  localparam logic [DAY_W-1:0] SECONDS_PER_MIN = 17'd60;

  localparam logic [SECONDS_W-1:0] SEC_LAST  = 6'd59;
  localparam logic [MINUTES_W-1:0] MIN_LAST  = 6'd59;
  localparam logic [6:0]           MIN_WRAP  = 7'd60;
  localparam logic [SECONDS_W-1:0] SEC_WRAP  = 6'd60;
  localparam logic [5:0]           HOUR_WRAP = 6'd24;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK         = 3'd0,
    FUNC_SET_TIME     = 3'd1,
    FUNC_READ_TIME    = 3'd2,
    FUNC_TAKE_UPDATE  = 3'd3,
    FUNC_TAKE_ALARM   = 3'd4,
    FUNC_BACKUP_WRITE = 3'd5,
    FUNC_BACKUP_READ  = 3'd6
  } func_e;

endpackage

>>> rtl/tdca_if.sv
// ----------------------------------------------------------------------------
// tdca_in_if / tdca_out_if
// Valid/ready channels that carry command items into the clock and result
// items out of it.
// ----------------------------------------------------------------------------
interface tdca_in_if
  import tdca_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [HOURS_W-1:0]    set_hours;
  logic [MINUTES_W-1:0]  set_minutes;
  logic [SECONDS_W-1:0]  set_seconds;
  logic [BKP_IDX_W-1:0]  backup_index;
  logic [BKP_DATA_W-1:0] backup_value;

  modport source (
    output valid, func, set_hours, set_minutes, set_seconds, backup_index, backup_value,
    input  ready
  );
  modport sink (
    input  valid, func, set_hours, set_minutes, set_seconds, backup_index, backup_value,
    output ready
  );
endinterface

interface tdca_out_if
  import tdca_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [HOURS_W-1:0]    time_hours;
  logic [MINUTES_W-1:0]  time_minutes;
  logic [SECONDS_W-1:0]  time_seconds;
  logic                  update_pending;
  logic                  alarm_hit;
  logic [BKP_DATA_W-1:0] backup_read_data;
  logic                  backup_valid;

  modport source (
    output valid, time_hours, time_minutes, time_seconds, update_pending, alarm_hit,
           backup_read_data, backup_valid,
    input  ready
  );
  modport sink (
    input  valid, time_hours, time_minutes, time_seconds, update_pending, alarm_hit,
           backup_read_data, backup_valid,
    output ready
  );
endinterface

>>> rtl/time_of_day_clock_with_alarm_top.sv
// ----------------------------------------------------------------------------
// time_of_day_clock_with_alarm_top
// Seconds clock with alarm, update and alarm flags, and a small backup store.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless a result waits at the
// output with the stage register full, and returns one result item for
// each. An item passes the stage register, with the registered read of the
// backup memory, then the output register; the time of day is kept as hours,
// minutes and seconds next to the running count, so no division is needed.
// A result may wait at the output while the next item is still taken. The
// backup memory needs no clearing pass after reset: each word has a valid bit.
module time_of_day_clock_with_alarm_top
  import tdca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tdca_in_if.sink               in_i,
  tdca_out_if.source            out_o
);

  logic [DAY_W-1:0] alarm_time_q;
  logic             alarm_en_q;

  logic [COUNT_W-1:0]   count_q, count_d;
  logic [DAY_W-1:0]     day_q, day_d;
  logic [HOURS_W-1:0]   hour_q, hour_d;
  logic [MINUTES_W-1:0] min_q, min_d;
  logic [SECONDS_W-1:0] sec_q, sec_d;
  logic                 upd_q, upd_d, upd_set;
  logic                 alm_q, alm_d, alm_set;
  logic                 bw_q, bw_d;

  logic [BKP_DATA_W-1:0] mem_q [BACKUP_WORDS];
  logic [BACKUP_WORDS-1:0] mem_vld_q;
  logic [BKP_DATA_W-1:0] mem_rdata_q;

  logic                 p_valid_q;
  logic [HOURS_W-1:0]   p_hour_q;
  logic [MINUTES_W-1:0] p_min_q;
  logic [SECONDS_W-1:0] p_sec_q;
  logic                 p_upd_q, p_alm_q, p_bw_q, p_rd_ok_q;

  logic                  o_valid_q;
  logic [HOURS_W-1:0]    o_hour_q;
  logic [MINUTES_W-1:0]  o_min_q;
  logic [SECONDS_W-1:0]  o_sec_q;
  logic                  o_upd_q, o_alm_q, o_bw_q;
  logic [BKP_DATA_W-1:0] o_rdata_q;

  logic                  in_acc, o_free, p_adv;
  func_e                 func;
  logic                  bkp_in_range;
  logic [BKP_ADDR_W-1:0] bkp_addr;
  logic                  bkp_wr, bkp_rd_ok;

  logic [DAY_W-1:0]     set_sum;
  logic [SECONDS_W-1:0] set_sec;
  logic                 set_c1, set_c2;
  logic [6:0]           set_min_t;
  logic [MINUTES_W-1:0] set_min;
  logic [5:0]           set_hour_t;
  logic [5:0]           set_hour;

  assign o_free       = !o_valid_q || out_o.ready;
  assign p_adv        = p_valid_q && o_free;
  assign in_i.ready   = !p_valid_q || o_free;
  assign in_acc       = in_i.valid && in_i.ready;
  assign func         = func_e'(in_i.func);
  assign bkp_in_range = 32'(in_i.backup_index) < BACKUP_WORDS;
  assign bkp_addr     = BKP_ADDR_W'(in_i.backup_index);
  assign bkp_wr       = in_acc && (func == FUNC_BACKUP_WRITE) && bkp_in_range;
  assign bkp_rd_ok    = (func == FUNC_BACKUP_READ) && bkp_in_range && mem_vld_q[bkp_addr];

  // Normalize a set-time request that may carry out-of-range fields.
  always_comb begin
    set_sum    = DAY_W'(in_i.set_hours) * SECONDS_PER_HR
               + DAY_W'(in_i.set_minutes) * SECONDS_PER_MIN
               + DAY_W'(in_i.set_seconds);
    set_c1     = in_i.set_seconds >= SEC_WRAP;
    set_sec    = set_c1 ? in_i.set_seconds - SEC_WRAP : in_i.set_seconds;
    set_min_t  = 7'(in_i.set_minutes) + 7'(set_c1);
    set_c2     = set_min_t >= MIN_WRAP;
    set_min    = MINUTES_W'(set_c2 ? set_min_t - MIN_WRAP : set_min_t);
    set_hour_t = 6'(in_i.set_hours) + 6'(set_c2);
    set_hour   = (set_hour_t >= HOUR_WRAP) ? set_hour_t - HOUR_WRAP : set_hour_t;
  end

  always_comb begin
    count_d = count_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    upd_set = upd_q;
    alm_set = alm_q;
    bw_d    = bw_q;
    case (func)
      FUNC_TICK: begin
        count_d = count_q + 1'b1;
        upd_set = 1'b1;
        if ((count_d == '0) || (day_q == DAY_LAST)) begin
          day_d  = '0;
          hour_d = '0;
          min_d  = '0;
          sec_d  = '0;
        end else begin
          day_d = day_q + 1'b1;
          if (sec_q == SEC_LAST) begin
            sec_d = '0;
            if (min_q == MIN_LAST) begin
              min_d  = '0;
              hour_d = hour_q + 1'b1;
            end else begin
              min_d = min_q + 1'b1;
            end
          end else begin
            sec_d = sec_q + 1'b1;
          end
        end
        if (alarm_en_q && (day_d == alarm_time_q)) begin
          alm_set = 1'b1;
        end
      end
      FUNC_SET_TIME: begin
        count_d = COUNT_W'(set_sum);
        day_d   = (set_sum >= SECONDS_PER_DAY) ? set_sum - SECONDS_PER_DAY : set_sum;
        hour_d  = HOURS_W'(set_hour);
        min_d   = set_min;
        sec_d   = set_sec;
      end
      FUNC_BACKUP_WRITE: begin
        if (bkp_in_range) begin
          bw_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    upd_d = (func == FUNC_TAKE_UPDATE) ? 1'b0 : upd_set;
    alm_d = (func == FUNC_TAKE_ALARM) ? 1'b0 : alm_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_time_q <= '0;
      alarm_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALARM_TIME:   alarm_time_q <= cfg_data_i[DAY_W-1:0];
        CFG_ALARM_ENABLE: alarm_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      upd_q     <= 1'b0;
      alm_q     <= 1'b0;
      bw_q      <= 1'b0;
      mem_vld_q <= '0;
    end else if (in_acc) begin
      count_q <= count_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      upd_q   <= upd_d;
      alm_q   <= alm_d;
      bw_q    <= bw_d;
      if (bkp_wr) begin
        mem_vld_q[bkp_addr] <= 1'b1;
      end
    end
  end

  // Backup memory: one write and one registered read per cycle in which an item is accepted.
  always_ff @(posedge clk_i) begin
    if (bkp_wr) begin
      mem_q[bkp_addr] <= in_i.backup_value;
    end
    if (in_acc && bkp_in_range) begin
      mem_rdata_q <= mem_q[bkp_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        p_valid_q <= 1'b1;
      end else if (p_adv) begin
        p_valid_q <= 1'b0;
      end
      if (o_free) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_hour_q  <= hour_d;
      p_min_q   <= min_d;
      p_sec_q   <= sec_d;
      p_upd_q   <= upd_set;
      p_alm_q   <= alm_set;
      p_bw_q    <= bw_d;
      p_rd_ok_q <= bkp_rd_ok;
    end
    if (p_adv) begin
      o_hour_q  <= p_hour_q;
      o_min_q   <= p_min_q;
      o_sec_q   <= p_sec_q;
      o_upd_q   <= p_upd_q;
      o_alm_q   <= p_alm_q;
      o_bw_q    <= p_bw_q;
      o_rdata_q <= p_rd_ok_q ? mem_rdata_q : '0;
    end
  end

  assign out_o.valid            = o_valid_q;
  assign out_o.time_hours       = o_hour_q;
  assign out_o.time_minutes     = o_min_q;
  assign out_o.time_seconds     = o_sec_q;
  assign out_o.update_pending   = o_upd_q;
  assign out_o.alarm_hit        = o_alm_q;
  assign out_o.backup_read_data = o_rdata_q;
  assign out_o.backup_valid     = o_bw_q;

  a_time_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q < SEC_WRAP) && (7'(min_q) < MIN_WRAP) && (6'(hour_q) < HOUR_WRAP))
    else $error("Time-of-day fields out of range.");

  a_day_matches_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_q == DAY_W'(hour_q) * SECONDS_PER_HR + DAY_W'(min_q) * SECONDS_PER_MIN
             + DAY_W'(sec_q))
    else $error("Seconds of day disagree with hours, minutes and seconds.");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !o_free) |=> (p_valid_q && $stable(p_hour_q) && $stable(mem_rdata_q)))
    else $error("Stalled item lost its stage contents.");

  a_backup_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bkp_wr |=> (bw_q && mem_vld_q != '0))
    else $error("Backup write did not mark the store valid.");

endmodule
